[src/directional_change_event_detector_core_macros.svh]
// Assertion macros shared by the detector RTL.
// Assertions assume a clock named clk and an active-low reset named arst_n.
`ifndef DIRECTIONAL_CHANGE_EVENT_DETECTOR_CORE_MACROS_SVH
`define DIRECTIONAL_CHANGE_EVENT_DETECTOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset
`define DCED_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Overlapping implication
`define DCED_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define DCED_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DCED_ASSERT(lbl, prop, msg)
`define DCED_ASSERT_IMP(lbl, ante, cons, msg)
`define DCED_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[src/dced_pkg.sv]
// Package for the directional-change event detector.
// Constants, word types and divider request struct; no dependencies.
package dced_pkg;
	localparam int MAX_RUN   = 16;
	localparam int RUN_W     = $clog2(MAX_RUN);
	localparam int PRICE_W   = 32;
	localparam int THR_W     = 23;
	localparam int MOVE_W    = 32;
	localparam int SUM_W     = MOVE_W + 1;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = 1;
	localparam int QCNT_W    = 2;
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = 6;

	localparam logic [THR_W-1:0] THR_RESET = 23'd83886;
	// 1.0 in Q8.24
	localparam logic [32:0] ONE_Q24 = 33'h001000000;

	// Word from front to engine: seed marks the very first tick
	typedef struct packed {
		logic               seed;
		logic               up;
		logic [PRICE_W-1:0] price;
	} dced_item_t;

	typedef struct packed {
		logic [PRICE_W-1:0] event_price;
		logic               upward;
		logic               last_of_run;
		logic               overrun;
	} dced_result_t;

	// Divider request: ratio (a - b) / den in Q8.24
	typedef struct packed {
		logic               start;
		logic [PRICE_W-1:0] a;
		logic [PRICE_W-1:0] b;
		logic [PRICE_W-1:0] den;
	} dced_div_req_t;
endpackage

[src/dced_front.sv]
// Front end: accepts ticks, drops repeats, tracks the last price.
// Queues seed and tick words for the engine. Uses dced_pkg.
module dced_front import dced_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [PRICE_W-1:0] price,
	output logic               item_empty,
	input  logic               item_pop,
	output dced_item_t         item_head
);
	logic               seeded_q;
	logic [PRICE_W-1:0] last_price_q;
	dced_item_t         items_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               accept;
	logic               enq;
	logic               deq;
	dced_item_t         new_item;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign item_empty = (cnt_q == '0);
	assign item_head  = items_q[rd_ptr_q];
	assign accept     = push && !full;
	assign deq        = item_pop && !item_empty;

	// classify: first tick seeds, repeated price is dropped
	always_comb begin
		new_item.seed  = !seeded_q;
		new_item.up    = price > last_price_q;
		new_item.price = price;
		enq            = accept && (!seeded_q || (price != last_price_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q     <= 1'b0;
			last_price_q <= '0;
		end else if (accept) begin
			seeded_q     <= 1'b1;
			last_price_q <= price;
		end
	end

	// two-word queue toward the engine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (deq) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (enq && !deq) cnt_q <= cnt_q + 1'b1;
			else if (deq && !enq) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (enq) items_q[wr_ptr_q] <= new_item;
	end
endmodule

[src/dced_div.sv]
// Iterative ratio divider: (a - b) << 24 / den, floored and saturated.
// One quotient bit per cycle; uses dced_pkg and the assertion macros.
`include "directional_change_event_detector_core_macros.svh"
module dced_div import dced_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  dced_div_req_t       req,
	output logic                done,
	output logic [MOVE_W-1:0]   quo
);
	logic [SUM_W-1:0]     rem_q;
	logic [PRICE_W-1:0]   den_q;
	logic [31:0]          shift_q;
	logic [MOVE_W-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [PRICE_W-1:0]   diff;
	logic [SUM_W-1:0]     trial;
	logic                 ge;

	assign diff  = (req.a > req.b) ? (req.a - req.b) : '0;
	assign trial = {rem_q[SUM_W-2:0], shift_q[31]};
	assign ge    = trial >= {1'b0, den_q};
	assign done  = done_q;
	assign quo   = quo_q;

	// control: shortcut for zero difference and quotient overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if ((diff == '0) || ({8'b0, diff} >= {req.den, 8'b0})) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= DIV_CNT_W'(DIV_STEPS);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: restoring division, quotient known to fit 32 bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q   <= req.den;
			rem_q   <= {9'b0, diff[31:8]};
			shift_q <= {diff[7:0], 24'b0};
			if (diff == '0) quo_q <= '0;
			else quo_q <= '1;
		end else if (busy_q) begin
			rem_q   <= ge ? (trial - {1'b0, den_q}) : trial;
			shift_q <= {shift_q[30:0], 1'b0};
			quo_q   <= {quo_q[MOVE_W-2:0], ge};
		end
	end

	`DCED_ASSERT(a_no_start_busy, !(req.start && busy_q), "divider started while busy")
	`DCED_ASSERT_IMP(a_busy_cnt, busy_q, cnt_q != '0, "busy divider with zero count")
	`DCED_ASSERT_IMP(a_done_idle, done_q, !busy_q, "divider done while still busy")
endmodule

[src/dced_engine.sv]
// Back end: updates the intrinsic event, fires event runs, queues results.
// Uses dced_pkg, dced_div and the assertion macros.
`include "directional_change_event_detector_core_macros.svh"
module dced_engine import dced_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [THR_W-1:0]   thr,
	input  logic               item_empty,
	output logic               item_pop,
	input  dced_item_t         item_head,
	output logic               empty,
	input  logic               pop,
	output dced_result_t       result
);
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_EXT   = 7'b0000010,
		ST_DN    = 7'b0000100,
		ST_UP    = 7'b0001000,
		ST_MUL   = 7'b0010000,
		ST_ROUND = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} st_t;

	st_t                state_q;
	logic [PRICE_W-1:0] price_q;
	logic               up_q;
	logic               ext_rise_q;
	logic [PRICE_W-1:0] start_q;
	logic [PRICE_W-1:0] high_q;
	logic [PRICE_W-1:0] low_q;
	logic [MOVE_W-1:0]  rise_q;
	logic [MOVE_W-1:0]  fall_q;
	logic [SUM_W-1:0]   mdown_q;
	logic [SUM_W-1:0]   remain_q;
	logic [PRICE_W-1:0] base_q;
	logic [31:0]        fac_q;
	logic [63:0]        prod_s1;
	logic [PRICE_W-1:0] ev_q;
	logic [RUN_W-1:0]   n_q;

	dced_div_req_t      div_req;
	logic               div_done;
	logic [MOVE_W-1:0]  div_quo;

	dced_result_t       res_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               out_push;
	logic               out_pop;
	dced_result_t       new_res;

	logic [SUM_W-1:0]   mup;
	logic [32:0]        fac_up;
	logic [33:0]        fac_dn;
	logic [64:0]        rnd;
	logic [SUM_W-1:0]   two_d;
	logic               ge2;
	logic               more;

	dced_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign item_pop = (state_q == ST_IDLE) && !item_empty;
	assign two_d    = {9'b0, thr, 1'b0};
	assign ge2      = remain_q >= two_d;
	assign more     = ge2 && (n_q != RUN_W'(MAX_RUN - 1));
	assign mup      = {1'b0, fall_q} + {1'b0, div_quo};
	// first-event factors: up clamps at zero, down clamps at 2^32-1
	assign fac_up   = ({1'b0, fall_q} > (ONE_Q24 + 33'(thr))) ? '0
		: (ONE_Q24 + 33'(thr) - {1'b0, fall_q});
	assign fac_dn   = {1'b0, ONE_Q24} - 34'(thr) + 34'(rise_q);
	assign rnd      = {1'b0, prod_s1} + 65'h000000000_00800000;

	// divider launches
	always_comb begin
		div_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (!item_empty && !item_head.seed) begin
					div_req.start = 1'b1;
					if (item_head.price > high_q) begin
						div_req.a   = item_head.price;
						div_req.b   = start_q;
						div_req.den = start_q;
					end else if (item_head.price < low_q) begin
						div_req.a   = start_q;
						div_req.b   = item_head.price;
						div_req.den = start_q;
					end else begin
						div_req.a   = high_q;
						div_req.b   = item_head.price;
						div_req.den = high_q;
					end
				end
			end
			ST_EXT: begin
				div_req.start = div_done;
				div_req.a     = high_q;
				div_req.b     = price_q;
				div_req.den   = high_q;
			end
			ST_DN: begin
				div_req.start = div_done;
				div_req.a     = price_q;
				div_req.b     = low_q;
				div_req.den   = low_q;
			end
			default: div_req = '0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= '0;
			high_q  <= '0;
			low_q   <= '0;
			rise_q  <= '0;
			fall_q  <= '0;
			n_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!item_empty) begin
						if (item_head.seed) begin
							start_q <= item_head.price;
							high_q  <= item_head.price;
							low_q   <= item_head.price;
							rise_q  <= '0;
							fall_q  <= '0;
						end else if (item_head.price > high_q) begin
							high_q  <= item_head.price;
							state_q <= ST_EXT;
						end else if (item_head.price < low_q) begin
							low_q   <= item_head.price;
							state_q <= ST_EXT;
						end else begin
							state_q <= ST_DN;
						end
					end
				end
				ST_EXT: begin
					if (div_done) begin
						if (ext_rise_q) rise_q <= div_quo;
						else fall_q <= div_quo;
						state_q <= ST_DN;
					end
				end
				ST_DN: begin
					if (div_done) state_q <= ST_UP;
				end
				ST_UP: begin
					if (div_done) begin
						n_q <= '0;
						if ((mdown_q < SUM_W'(thr)) && (mup < SUM_W'(thr))) state_q <= ST_IDLE;
						else state_q <= ST_MUL;
					end
				end
				ST_MUL:   state_q <= ST_ROUND;
				ST_ROUND: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (cnt_q != QCNT_W'(QDEPTH)) begin
						if (more) begin
							n_q     <= n_q + 1'b1;
							state_q <= ST_MUL;
						end else begin
							start_q <= ev_q;
							high_q  <= ev_q;
							low_q   <= ev_q;
							rise_q  <= '0;
							fall_q  <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers of the run
	always_ff @(posedge clk) begin
		if (item_pop) begin
			price_q    <= item_head.price;
			up_q       <= item_head.up;
			ext_rise_q <= item_head.price > high_q;
		end
		if ((state_q == ST_DN) && div_done) mdown_q <= {1'b0, rise_q} + {1'b0, div_quo};
		if ((state_q == ST_UP) && div_done) begin
			if (up_q) begin
				remain_q <= mup;
				base_q   <= low_q;
				fac_q    <= fac_up[31:0];
			end else begin
				remain_q <= mdown_q;
				base_q   <= high_q;
				fac_q    <= (fac_dn[33:32] != 2'b0) ? '1 : fac_dn[31:0];
			end
		end
		if (state_q == ST_MUL) prod_s1 <= 64'(base_q) * 64'(fac_q);
		if (state_q == ST_ROUND) ev_q <= (rnd[64:56] != '0) ? '1 : rnd[55:24];
		if ((state_q == ST_EMIT) && (cnt_q != QCNT_W'(QDEPTH)) && more) begin
			base_q   <= ev_q;
			remain_q <= remain_q - SUM_W'(thr);
			fac_q    <= up_q ? 32'(ONE_Q24 + 33'(thr)) : 32'(ONE_Q24 - 33'(thr));
		end
	end

	// result queue
	assign out_push            = (state_q == ST_EMIT) && (cnt_q != QCNT_W'(QDEPTH));
	assign out_pop             = pop && (cnt_q != '0);
	assign empty               = (cnt_q == '0);
	assign result              = res_q[rd_ptr_q];
	assign new_res.event_price = ev_q;
	assign new_res.upward      = up_q;
	assign new_res.last_of_run = !more;
	assign new_res.overrun     = !more && ge2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (out_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (out_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (out_push && !out_pop) cnt_q <= cnt_q + 1'b1;
			else if (out_pop && !out_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_push) res_q[wr_ptr_q] <= new_res;
	end

	`DCED_ASSERT(a_state_onehot, $onehot(state_q), "engine state not one-hot")
	`DCED_ASSERT(a_out_cnt, cnt_q <= QCNT_W'(QDEPTH), "result queue overfilled")
	`DCED_ASSERT_IMP(a_pop_idle, item_pop, state_q == ST_IDLE, "word taken while busy")
	`DCED_ASSERT_NXT(a_last_idle, out_push && !more, state_q == ST_IDLE,
		"run did not end after last event")
endmodule

[src/directional_change_event_detector_core.sv]
// Directional-change event detector. Takes unsigned Q16.16 price ticks and
// emits intrinsic-time event prices. The front end accepts a tick whenever
// it is not full and queues it unless it repeats the last price. A changed
// tick then needs two or three ratio divisions on one shared divider. A
// division runs bit by bit, but is cut short when the ratio is zero or
// saturates. Each emitted event passes through the multiply, round and emit
// states, and a changed tick emits up to sixteen events. The emit state
// stalls while the output queue is full. Two ticks wait in the front queue
// and two results in the output queue. The threshold register is written
// through the cfg channel (always ready); the user must write it only while
// the block is idle, as the block itself does not enforce this.
// Uses dced_pkg, dced_front and dced_engine.
module directional_change_event_detector_core import dced_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [PRICE_W-1:0] price,
	output logic               empty,
	input  logic               pop,
	output logic [PRICE_W-1:0] event_price,
	output logic               upward,
	output logic               last_of_run,
	output logic               overrun,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [THR_W-1:0]   cfg_data
);
	logic [THR_W-1:0] thr_q;
	logic             item_empty;
	logic             item_pop;
	dced_item_t       item_head;
	dced_result_t     result;

	// threshold register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= THR_RESET;
		else if (cfg_valid && cfg_ready) thr_q <= cfg_data;
	end

	dced_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.price      (price),
		.item_empty (item_empty),
		.item_pop   (item_pop),
		.item_head  (item_head)
	);

	dced_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.thr        (thr_q),
		.item_empty (item_empty),
		.item_pop   (item_pop),
		.item_head  (item_head),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

	assign event_price = result.event_price;
	assign upward      = result.upward;
	assign last_of_run = result.last_of_run;
	assign overrun     = result.overrun;
endmodule

[dv/testbench.sv]
// Testbench for directional_change_event_detector_core: drives price ticks,
// predicts event prices from a behavioral model and checks every result word.
// Depends on dced_pkg and the detector RTL.
`timescale 1ns / 1ps

module testbench;
	import dced_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 400;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [PRICE_W-1:0] price;
	logic               empty;
	logic               pop;
	logic [PRICE_W-1:0] event_price;
	logic               upward;
	logic               last_of_run;
	logic               overrun;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [THR_W-1:0]   cfg_data;

	directional_change_event_detector_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .price(price),
		.empty(empty), .pop(pop), .event_price(event_price), .upward(upward),
		.last_of_run(last_of_run), .overrun(overrun), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Detector state mirror
	logic [THR_W-1:0]   thr;
	logic               m_seeded;
	logic [PRICE_W-1:0] m_last, m_start, m_high, m_low;
	logic [31:0]        m_rise, m_fall;

	dced_result_t expected_events[$];
	int  mismatches;
	int  events_seen;
	int  ticks_sent;
	int  overruns_seen;
	int  idle_cycles;
	bit  rx_stall_on;
	bit  timed_out;

	// 10 ns clock, low half first
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Ratio (a - b) / den in Q8.24, saturated
	function automatic logic [31:0] rel_ratio(logic [31:0] a, logic [31:0] b,
			logic [31:0] den);
		logic [63:0] diff;
		logic [63:0] q;
		diff = (a > b) ? 64'(a - b) : 64'd0;
		if (den == 0)
			return (diff == 0) ? 32'd0 : 32'hFFFF_FFFF;
		q = (diff << 24) / den;
		return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	// price * Q8.24 factor, round half up, factor and result clamped
	function automatic logic [31:0] scale(logic [31:0] p, longint factor);
		logic [63:0] f;
		logic [63:0] prod;
		if (factor < 0)
			f = 0;
		else if (factor > 64'sh0_FFFF_FFFF)
			f = 64'hFFFF_FFFF;
		else
			f = factor;
		prod = (64'(p) * f + 64'h80_0000) >> 24;
		return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
	endfunction

	function automatic void predict_events(logic [PRICE_W-1:0] p);
		longint       d;
		longint       down_sum, up_sum, remaining, factor;
		logic [31:0]  ev;
		bit           rising;
		int           n;
		dced_result_t r;
		d = thr;
		if (!m_seeded) begin
			m_seeded = 1'b1;
			m_last = p; m_start = p; m_high = p; m_low = p;
			m_rise = 0; m_fall = 0;
		end
		if (p == m_last)
			return;
		rising = p > m_last;
		m_last = p;
		if (p > m_high) begin
			m_high = p;
			m_rise = rel_ratio(m_high, m_start, m_start);
		end else if (p < m_low) begin
			m_low = p;
			m_fall = rel_ratio(m_start, m_low, m_start);
		end
		down_sum = longint'(m_rise) + rel_ratio(m_high, p, m_high);
		up_sum   = longint'(m_fall) + rel_ratio(p, m_low, m_low);
		if (down_sum < d && up_sum < d)
			return;
		if (rising) begin
			remaining = up_sum;
			factor = 64'sh100_0000 + d - longint'(m_fall);
			ev = scale(m_low, factor);
		end else begin
			remaining = down_sum;
			factor = 64'sh100_0000 - d + longint'(m_rise);
			ev = scale(m_high, factor);
		end
		n = 0;
		while (remaining >= 2 * d && n < MAX_RUN - 1) begin
			r = '{event_price: ev, upward: rising, last_of_run: 1'b0, overrun: 1'b0};
			expected_events.insert(expected_events.size(), r);
			n++;
			ev = scale(ev, rising ? 64'sh100_0000 + d : 64'sh100_0000 - d);
			remaining -= d;
		end
		r = '{event_price: ev, upward: rising, last_of_run: 1'b1,
			overrun: remaining >= 2 * d};
		expected_events.insert(expected_events.size(), r);
		m_start = ev; m_high = ev; m_low = ev;
		m_rise = 0; m_fall = 0;
	endfunction

	function automatic int random_gap();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 3);
	endfunction

	// Send one tick; push stays high into a back-to-back tick, the prediction
	// is made on acceptance
	task automatic send_tick(logic [PRICE_W-1:0] p, bit gaps = 1);
		int gap;
		gap = gaps ? random_gap() : 0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push  <= 1'b1;
		price <= p;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_events(p);
		ticks_sent++;
	endtask

	// Drop push, wait for the queue of expectations to empty, then let the
	// engine settle
	task automatic wait_idle();
		push <= 1'b0;
		while (expected_events.size() != 0 && !timed_out)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(logic [THR_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		thr = value;
	endtask

	// Result checker with a random pop stall
	always @(posedge clk) begin
		dced_result_t got, want;
		if (arst_n) begin
			if (pop && !empty) begin
				got = '{event_price: event_price, upward: upward,
					last_of_run: last_of_run, overrun: overrun};
				events_seen++;
				if (overrun)
					overruns_seen++;
				if (expected_events.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected event word %h/%b/%b/%b",
							event_price, upward, last_of_run, overrun);
				end else begin
					want = expected_events.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: event word expected %h/%b/%b/%b got %h/%b/%b/%b",
								want.event_price, want.upward, want.last_of_run,
								want.overrun, event_price, upward, last_of_run, overrun);
					end
				end
			end
			if ($urandom_range(0, 49) == 0)
				rx_stall_on <= ~rx_stall_on;
			pop <= rx_stall_on ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 3) != 0);
		end
	end

	// Watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic test_reset_threshold();
		send_tick(32'h0064_0000, 0);
		send_tick(32'h0064_0000);
		send_tick(32'h0065_0000);
		send_tick(32'h0062_0000);
		send_tick(32'h0061_0000);
		send_tick(32'h0066_0000);
	endtask

	task automatic test_price_extremes();
		send_tick(32'h0000_0001);
		send_tick(32'hFFFF_FFFF);
		send_tick(32'h0000_0001);
		send_tick(32'h8000_0000);
		send_tick(32'h7FFF_FFFF);
		send_tick(32'hFFFF_FFFE);
	endtask

	task automatic test_large_threshold();
		write_threshold(23'h7F_FFFF);
		send_tick(32'h0010_0000);
		send_tick(32'h0030_0000);
		send_tick(32'h0008_0000);
		send_tick(32'h0001_0000);
		send_tick(32'h00FF_0000);
	endtask

	// Smallest threshold first, so its changed ticks run up to the cap; then a large threshold
	task automatic test_run_cap();
		write_threshold(23'd1);
		send_tick(32'h0100_0000);
		send_tick(32'h0100_1000);
		send_tick(32'h00F0_0000);
		write_threshold(23'd4_000_000);
		send_tick(32'h0500_0000);
		send_tick(32'h0010_0000);
	endtask

	// Random walks with occasional jumps and repeats; a new threshold every 30 ticks
	task automatic test_random_walk(int count);
		logic [PRICE_W-1:0] p;
		logic [PRICE_W-1:0] step;
		p = 32'h0064_0000;
		for (int i = 0; i < count; i++) begin
			if (i % 30 == 0)
				write_threshold(($urandom_range(0, 3) == 0)
					? THR_W'($urandom_range(1, 23'h7F_FFFF))
					: THR_W'($urandom_range(20_000, 900_000)));
			if ($urandom_range(0, 9) == 0)
				p = $urandom_range(1, 32'hFFFF_FFFF);
			else if ($urandom_range(0, 9) == 0)
				p = p;
			else begin
				step = $urandom_range(0, 32'h0004_0000);
				if ($urandom_range(0, 1) && p > step)
					p = p - step;
				else if (p < 32'hFFF0_0000)
					p = p + step;
			end
			if (p == 0)
				p = 1;
			send_tick(p);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0; price = '0; pop = 1'b0;
		cfg_valid = 1'b0; cfg_data = '0;
		thr = THR_RESET;
		m_seeded = 0; m_last = 0; m_start = 0; m_high = 0; m_low = 0;
		m_rise = 0; m_fall = 0;
		mismatches = 0; events_seen = 0; ticks_sent = 0; overruns_seen = 0;
		idle_cycles = 0; rx_stall_on = 0; timed_out = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_threshold();
		test_price_extremes();
		test_large_threshold();
		test_run_cap();
		test_random_walk(100);
		wait_idle();

		if (expected_events.size() != 0) begin
			mismatches++;
			$display("ERROR: %0d event words never arrived", expected_events.size());
		end
		$display("Sent %0d ticks, checked %0d event words (%0d overrun), %0d mismatches",
			ticks_sent, events_seen, overruns_seen, mismatches);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
